>>> hdl/shec_pkg.sv
`timescale 1ns / 1ps
// Package for the stepper hall extend controller: widths, phase and register codes,
// configuration and result structs, and the coil phase tables.
// No dependencies.
package shec_pkg;

	localparam int POSITION_WIDTH = 16;
	localparam int TIMER_WIDTH    = 24;
	localparam int CFG_ADDR_W     = 5;
	localparam int CFG_DATA_W     = 32;

	localparam logic [TIMER_WIDTH-1:0] TMR_MAX = {TIMER_WIDTH{1'b1}};

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_EXTEND  = 2'd1,
		CMD_RETRACT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		WIRE_TWO  = 2'd0,
		WIRE_FOUR = 2'd1,
		WIRE_FIVE = 2'd2,
		WIRE_HOLD = 2'd3
	} wire_mode_t;

	typedef enum logic [2:0] {
		REG_STEPS_PER_REV  = 3'd0,
		REG_STEP_INTERVAL  = 3'd1,
		REG_HALL_THRESHOLD = 3'd2,
		REG_RETRACT_STEPS  = 3'd3,
		REG_WIRE_MODE      = 3'd4,
		REG_ENABLE_SETTLE  = 3'd5,
		REG_STEP_SETTLE    = 3'd6,
		REG_DISABLE_SETTLE = 3'd7
	} cfg_reg_t;

	typedef enum logic [6:0] {
		PH_IDLE            = 7'b0000001,
		PH_EXT_SETTLE      = 7'b0000010,
		PH_EXT_CHECK       = 7'b0000100,
		PH_EXT_STEP        = 7'b0001000,
		PH_EXT_STEP_SETTLE = 7'b0010000,
		PH_RET_STEP        = 7'b0100000,
		PH_RET_SETTLE      = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [POSITION_WIDTH-1:0] steps_per_rev;
		logic [TIMER_WIDTH-1:0]    step_interval;
		logic [9:0]                hall_threshold;
		logic signed [15:0]        retract_steps;
		wire_mode_t                wire_mode;
		logic [TIMER_WIDTH-1:0]    enable_settle_ticks;
		logic [TIMER_WIDTH-1:0]    step_settle_ticks;
		logic [TIMER_WIDTH-1:0]    disable_settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic [4:0]                phase_pins;
		logic                      enable;
		logic                      extended;
		logic                      busy_res;
		logic [POSITION_WIDTH-1:0] position;
	} res_t;

	function automatic logic [4:0] two_wire_coil(input logic [1:0] idx);
		logic [4:0] c;
		unique case (idx)
			2'd0: c = 5'd2;
			2'd1: c = 5'd3;
			2'd2: c = 5'd1;
			default: c = 5'd0;
		endcase
		return c;
	endfunction

	function automatic logic [4:0] four_wire_coil(input logic [1:0] idx);
		logic [4:0] c;
		unique case (idx)
			2'd0: c = 5'd5;
			2'd1: c = 5'd6;
			2'd2: c = 5'd10;
			default: c = 5'd9;
		endcase
		return c;
	endfunction

	function automatic logic [4:0] five_wire_coil(input logic [3:0] idx);
		logic [4:0] c;
		unique case (idx)
			4'd0: c = 5'd22;
			4'd1: c = 5'd18;
			4'd2: c = 5'd26;
			4'd3: c = 5'd10;
			4'd4: c = 5'd11;
			4'd5: c = 5'd9;
			4'd6: c = 5'd13;
			4'd7: c = 5'd5;
			4'd8: c = 5'd21;
			4'd9: c = 5'd20;
			default: c = 5'd0;
		endcase
		return c;
	endfunction

	// x mod 10 for a 16-bit x: quotient by reciprocal 52429 / 2^19, exact over the range
	function automatic logic [3:0] mod10(input logic [15:0] x);
		logic [31:0] p;
		logic [12:0] q;
		logic [15:0] r;
		p = {16'b0, x} * 32'd52429;
		q = p[31:19];
		r = x - {q, 3'b000} - {2'b00, q, 1'b0};
		return r[3:0];
	endfunction

endpackage

>>> hdl/shec_item_if.sv
`timescale 1ns / 1ps
// Input channel: one tick word with command and hall sample, valid/ready handshake.
// No dependencies: the field widths are written out here.
interface shec_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [9:0] hall_sample;

	modport source (output valid, output cmd, output hall_sample, input ready);
	modport sink (input valid, input cmd, input hall_sample, output ready);
endinterface

>>> hdl/shec_result_if.sv
`timescale 1ns / 1ps
// Result channel: coil pins, enable, extended, busy and position, valid/ready handshake.
// Uses shec_pkg for the position width.
interface shec_result_if;
	logic                               valid;
	logic                               ready;
	logic [4:0]                         phase_pins;
	logic                               enable;
	logic                               extended;
	logic                               busy_res;
	logic [shec_pkg::POSITION_WIDTH-1:0] position;

	modport source (output valid, output phase_pins, output enable, output extended,
		output busy_res, output position, input ready);
	modport sink (input valid, input phase_pins, input enable, input extended,
		input busy_res, input position, output ready);
endinterface

>>> hdl/shec_regs.sv
`timescale 1ns / 1ps
// APB-style configuration register file for the controller.
// Uses shec_pkg for the register codes and the configuration struct.
module shec_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [shec_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [shec_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [shec_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	output shec_pkg::cfg_t                    cfg
);

	shec_pkg::cfg_t     cfg_q;
	shec_pkg::cfg_reg_t sel;
	logic               wr;

	assign pready = 1'b1;
	assign sel    = shec_pkg::cfg_reg_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steps_per_rev        <= 16'd200;
			cfg_q.step_interval        <= 24'd3000;
			cfg_q.hall_threshold       <= 10'd512;
			cfg_q.retract_steps        <= 16'sd100;
			cfg_q.wire_mode            <= shec_pkg::WIRE_TWO;
			cfg_q.enable_settle_ticks  <= 24'd100000;
			cfg_q.step_settle_ticks    <= 24'd1000;
			cfg_q.disable_settle_ticks <= 24'd200000;
		end else if (wr) begin
			unique case (sel)
				shec_pkg::REG_STEPS_PER_REV:  cfg_q.steps_per_rev <= pwdata[15:0];
				shec_pkg::REG_STEP_INTERVAL:  cfg_q.step_interval <= pwdata[23:0];
				shec_pkg::REG_HALL_THRESHOLD: cfg_q.hall_threshold <= pwdata[9:0];
				shec_pkg::REG_RETRACT_STEPS:  cfg_q.retract_steps <= pwdata[15:0];
				shec_pkg::REG_WIRE_MODE:
					cfg_q.wire_mode <= shec_pkg::wire_mode_t'(pwdata[1:0]);
				shec_pkg::REG_ENABLE_SETTLE:  cfg_q.enable_settle_ticks <= pwdata[23:0];
				shec_pkg::REG_STEP_SETTLE:    cfg_q.step_settle_ticks <= pwdata[23:0];
				shec_pkg::REG_DISABLE_SETTLE: cfg_q.disable_settle_ticks <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			shec_pkg::REG_STEPS_PER_REV:  prdata = {16'b0, cfg_q.steps_per_rev};
			shec_pkg::REG_STEP_INTERVAL:  prdata = {8'b0, cfg_q.step_interval};
			shec_pkg::REG_HALL_THRESHOLD: prdata = {22'b0, cfg_q.hall_threshold};
			shec_pkg::REG_RETRACT_STEPS:  prdata = {16'b0, cfg_q.retract_steps};
			shec_pkg::REG_WIRE_MODE:      prdata = {30'b0, cfg_q.wire_mode};
			shec_pkg::REG_ENABLE_SETTLE:  prdata = {8'b0, cfg_q.enable_settle_ticks};
			shec_pkg::REG_STEP_SETTLE:    prdata = {8'b0, cfg_q.step_settle_ticks};
			shec_pkg::REG_DISABLE_SETTLE: prdata = {8'b0, cfg_q.disable_settle_ticks};
			default:                      prdata = '0;
		endcase
	end

endmodule

>>> hdl/shec_seq.sv
`timescale 1ns / 1ps
// Extend/retract sequencer: phase machine, step pacing, settle waits, position and coils.
// Uses shec_pkg for phase codes, tables and the configuration and result structs.
module shec_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic [1:0]     cmd,
	input  logic [9:0]     hall_sample,
	input  shec_pkg::cfg_t cfg,
	output shec_pkg::res_t res
);

	localparam int PW = shec_pkg::POSITION_WIDTH;
	localparam int TW = shec_pkg::TIMER_WIDTH;

	shec_pkg::phase_t phase_q, phase_d;
	logic [PW-1:0]    pos_q, pos_d, step_pos;
	logic             dir_q, dir_d, step_dir, step_go;
	logic [TW-1:0]    tss_q, tss_d, tss_inc;
	logic [TW-1:0]    wc_q, wc_d, wait_tgt;
	logic [15:0]      sr_q, sr_d, sr_n;
	logic             ext_q, ext_d, en_q, en_d;
	logic [4:0]       coil_q, coil_d, coil_step;
	logic             pace_ok, wait_done;
	logic [PW-1:0]    pos_inc;

	assign tss_inc   = (tss_q == shec_pkg::TMR_MAX) ? tss_q : tss_q + 1'b1;
	assign pace_ok   = tss_inc >= cfg.step_interval;
	assign wait_done = (wc_q >= wait_tgt) || (wc_q == shec_pkg::TMR_MAX);
	assign step_dir  = (phase_q == shec_pkg::PH_RET_STEP) ? dir_q : 1'b0;
	assign pos_inc   = pos_q + 1'b1;

	always_comb begin
		unique case (phase_q)
			shec_pkg::PH_EXT_STEP_SETTLE: wait_tgt = cfg.step_settle_ticks;
			shec_pkg::PH_RET_SETTLE:      wait_tgt = cfg.disable_settle_ticks;
			default:                      wait_tgt = cfg.enable_settle_ticks;
		endcase
	end

	// Position after one step; out-of-range positions snap to 0 going forward, to steps_per_rev-1 going back
	always_comb begin
		if (cfg.steps_per_rev == '0) begin
			step_pos = '0;
		end else if (step_dir) begin
			step_pos = (pos_q >= cfg.steps_per_rev || pos_inc >= cfg.steps_per_rev)
				? '0 : pos_inc;
		end else begin
			step_pos = (pos_q == '0 || pos_q >= cfg.steps_per_rev)
				? cfg.steps_per_rev - 1'b1 : pos_q - 1'b1;
		end
	end

	always_comb begin
		unique case (cfg.wire_mode)
			shec_pkg::WIRE_TWO:  coil_step = shec_pkg::two_wire_coil(step_pos[1:0]);
			shec_pkg::WIRE_FOUR: coil_step = shec_pkg::four_wire_coil(step_pos[1:0]);
			shec_pkg::WIRE_FIVE: coil_step = shec_pkg::five_wire_coil(shec_pkg::mod10(step_pos));
			default:             coil_step = coil_q;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		dir_d   = dir_q;
		wc_d    = wc_q;
		sr_d    = sr_q;
		ext_d   = ext_q;
		en_d    = en_q;
		step_go = 1'b0;
		sr_n    = sr_q;
		unique case (phase_q)
			shec_pkg::PH_EXT_SETTLE: begin
				if (wait_done) phase_d = shec_pkg::PH_EXT_CHECK;
				else wc_d = wc_q + 1'b1;
			end
			shec_pkg::PH_EXT_CHECK, shec_pkg::PH_EXT_STEP: begin
				if (phase_q == shec_pkg::PH_EXT_CHECK && hall_sample <= cfg.hall_threshold) begin
					ext_d   = 1'b1;
					phase_d = shec_pkg::PH_IDLE;
				end else if (pace_ok) begin
					dir_d   = 1'b0;
					step_go = 1'b1;
					wc_d    = '0;
					phase_d = shec_pkg::PH_EXT_STEP_SETTLE;
				end else begin
					phase_d = shec_pkg::PH_EXT_STEP;
				end
			end
			shec_pkg::PH_EXT_STEP_SETTLE: begin
				if (wait_done) phase_d = shec_pkg::PH_EXT_CHECK;
				else wc_d = wc_q + 1'b1;
			end
			shec_pkg::PH_RET_STEP: begin
				if (sr_q != '0 && pace_ok) begin
					step_go = 1'b1;
					sr_n    = sr_q - 1'b1;
				end
				sr_d = sr_n;
				if (sr_n == '0) begin
					wc_d    = '0;
					phase_d = shec_pkg::PH_RET_SETTLE;
				end
			end
			shec_pkg::PH_RET_SETTLE: begin
				if (wait_done) begin
					en_d    = 1'b0;
					ext_d   = 1'b0;
					phase_d = shec_pkg::PH_IDLE;
				end else begin
					wc_d = wc_q + 1'b1;
				end
			end
			default: begin
				// idle, and any code that is not a phase
				phase_d = shec_pkg::PH_IDLE;
				if (cmd == shec_pkg::CMD_EXTEND && !ext_q) begin
					en_d    = 1'b1;
					wc_d    = '0;
					phase_d = shec_pkg::PH_EXT_SETTLE;
				end else if (cmd == shec_pkg::CMD_RETRACT) begin
					if (cfg.retract_steps[15]) begin
						dir_d = 1'b0;
						sr_d  = 16'd0 - cfg.retract_steps;
					end else begin
						if (cfg.retract_steps != '0) dir_d = 1'b1;
						sr_d = cfg.retract_steps;
					end
					phase_d = shec_pkg::PH_RET_STEP;
				end
			end
		endcase
		if (step_go) begin
			pos_d  = step_pos;
			coil_d = coil_step;
			tss_d  = '0;
		end else begin
			pos_d  = pos_q;
			coil_d = coil_q;
			tss_d  = tss_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= shec_pkg::PH_IDLE;
			pos_q   <= '0;
			dir_q   <= 1'b0;
			tss_q   <= shec_pkg::TMR_MAX;
			wc_q    <= '0;
			sr_q    <= '0;
			ext_q   <= 1'b0;
			en_q    <= 1'b0;
			coil_q  <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			dir_q   <= dir_d;
			tss_q   <= tss_d;
			wc_q    <= wc_d;
			sr_q    <= sr_d;
			ext_q   <= ext_d;
			en_q    <= en_d;
			coil_q  <= coil_d;
		end
	end

	assign res.phase_pins = coil_d;
	assign res.enable     = en_d;
	assign res.extended   = ext_d;
	assign res.busy_res   = phase_d != shec_pkg::PH_IDLE;
	assign res.position   = pos_d;

endmodule

>>> hdl/stepper_hall_extend_controller.sv
`timescale 1ns / 1ps
// Top level of the stepper hall extend controller: input register, sequencer, result register.
// Depends on shec_pkg, shec_item_if, shec_result_if, shec_regs and shec_seq.
//
//   channel   direction  handshake            payload
//   item      in         valid/ready          cmd, hall_sample
//   result    out        valid/ready          phase_pins, enable, extended, busy_res, position
//   apb       in         psel/penable/pready  paddr, pwdata, prdata (8 registers at 4*i)
//
// One word per clock while the result side keeps taking them; a tick word lands in the input
// register when accepted and moves on into the result register (the sequencer's single pass)
// once the result slot is free or being emptied; its result is offered from there.
// Reset puts the phase machine in idle, position 0, pacing timer saturated, enable low.
// A stalled result holds the input register; the input side keeps taking words as long
// as the held word can move on in the same cycle.
module stepper_hall_extend_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	shec_item_if.sink                       item,
	shec_result_if.source                   result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [shec_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [shec_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [shec_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);

	shec_pkg::cfg_t cfg;
	shec_pkg::res_t res_next;
	shec_pkg::res_t res_q;
	logic           valid_s1;
	logic [1:0]     cmd_s1;
	logic [9:0]     hall_s1;
	logic           res_valid_q;
	logic           adv;

	shec_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// advance the held word when the result slot is free or being emptied
	assign adv        = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item.valid && item.ready) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1  <= item.cmd;
			hall_s1 <= item.hall_sample;
		end
		if (adv) res_q <= res_next;
	end

	shec_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.cmd        (cmd_s1),
		.hall_sample(hall_s1),
		.cfg        (cfg),
		.res        (res_next)
	);

	assign result.valid      = res_valid_q;
	assign result.phase_pins = res_q.phase_pins;
	assign result.enable     = res_q.enable;
	assign result.extended   = res_q.extended;
	assign result.busy_res   = res_q.busy_res;
	assign result.position   = res_q.position;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for stepper_hall_extend_controller: directed tick table, long retract sweeps and
// randomized phases, each tick word checked against a fixed result or a cycle-free model of the sequencer.
// Depends on shec_pkg, shec_item_if, shec_result_if and the controller RTL.
module tb_top;
	import shec_pkg::*;

	typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		cfg_reg_t   rsel;
		logic [31:0] val;
		cmd_t       cmd;
		logic [9:0] hall;
		bit         typed;
		res_t       want;
	} plan_row_t;

	localparam logic [4:0] COILS_2W [4]  = '{5'd2, 5'd3, 5'd1, 5'd0};
	localparam logic [4:0] COILS_4W [4]  = '{5'd5, 5'd6, 5'd10, 5'd9};
	localparam logic [4:0] COILS_5W [10] = '{5'd22, 5'd18, 5'd26, 5'd10, 5'd11,
		5'd9, 5'd13, 5'd5, 5'd21, 5'd20};

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata, prdata;

	shec_item_if item_ch ();
	shec_result_if res_ch ();

	stepper_hall_extend_controller DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #6 clk = ~clk;

	// register copy, reset values
	logic [15:0] spr         = 16'd200;
	logic [23:0] interval    = 24'd3000;
	logic [9:0]  thresh      = 10'd512;
	logic [15:0] ret_cnt     = 16'd100;
	wire_mode_t  wmode       = WIRE_TWO;
	logic [23:0] settle_en   = 24'd100000;
	logic [23:0] settle_step = 24'd1000;
	logic [23:0] settle_dis  = 24'd200000;

	// sequencer state, reset values
	phase_t      phase      = PH_IDLE;
	logic [15:0] pos        = '0;
	bit          fwd        = 1'b0;
	logic [23:0] since_step = TMR_MAX;
	logic [23:0] wait_cnt   = '0;
	logic [15:0] ret_left   = '0;
	bit          at_extend  = 1'b0;
	bit          drv_en     = 1'b0;
	logic [4:0]  coils      = '0;

	res_t drive_q [$];
	plan_row_t plan [$];
	int unsigned burst_left = 0;
	int unsigned bad_words = 0;
	int unsigned words_seen = 0;

	function automatic void step_motor();
		logic [15:0] nxt;
		since_step = '0;
		nxt = pos + 16'd1;
		if (spr == 16'd0)
			pos = '0;
		else if (fwd)
			pos = (pos >= spr || nxt >= spr) ? 16'd0 : nxt;
		else
			pos = (pos == 16'd0 || pos >= spr) ? spr - 16'd1 : pos - 16'd1;
		case (wmode)
			WIRE_TWO:  coils = COILS_2W[pos[1:0]];
			WIRE_FOUR: coils = COILS_4W[pos[1:0]];
			WIRE_FIVE: coils = COILS_5W[pos % 16'd10];
			default: ;
		endcase
	endfunction

	function automatic bit settle_done(logic [23:0] target);
		if (wait_cnt >= target || wait_cnt == TMR_MAX)
			return 1'b1;
		wait_cnt = wait_cnt + 24'd1;
		return 1'b0;
	endfunction

	// one timer tick of the sequencer; returns the drive state after the tick
	function automatic res_t tick_controller(cmd_t c, logic [9:0] hall);
		res_t r;
		if (since_step != TMR_MAX)
			since_step = since_step + 24'd1;
		case (phase)
			PH_EXT_SETTLE: if (settle_done(settle_en)) phase = PH_EXT_CHECK;
			PH_EXT_CHECK, PH_EXT_STEP: begin
				if (phase == PH_EXT_CHECK && hall <= thresh) begin
					at_extend = 1'b1;
					phase = PH_IDLE;
				end else begin
					phase = PH_EXT_STEP;
					if (since_step >= interval) begin
						fwd = 1'b0;
						step_motor();
						wait_cnt = '0;
						phase = PH_EXT_STEP_SETTLE;
					end
				end
			end
			PH_EXT_STEP_SETTLE: if (settle_done(settle_step)) phase = PH_EXT_CHECK;
			PH_RET_STEP: begin
				if (ret_left != 16'd0 && since_step >= interval) begin
					step_motor();
					ret_left = ret_left - 16'd1;
				end
				if (ret_left == 16'd0) begin
					wait_cnt = '0;
					phase = PH_RET_SETTLE;
				end
			end
			PH_RET_SETTLE: if (settle_done(settle_dis)) begin
				drv_en = 1'b0;
				at_extend = 1'b0;
				phase = PH_IDLE;
			end
			default: begin
				phase = PH_IDLE;
				if (c == CMD_EXTEND && !at_extend) begin
					drv_en = 1'b1;
					wait_cnt = '0;
					phase = PH_EXT_SETTLE;
				end else if (c == CMD_RETRACT) begin
					if (ret_cnt[15]) begin
						fwd = 1'b0;
						ret_left = 16'd0 - ret_cnt;
					end else begin
						if (ret_cnt != 16'd0)
							fwd = 1'b1;
						ret_left = ret_cnt;
					end
					phase = PH_RET_STEP;
				end
			end
		endcase
		r.phase_pins = coils;
		r.enable     = drv_en;
		r.extended   = at_extend;
		r.busy_res   = (phase != PH_IDLE);
		r.position   = pos;
		return r;
	endfunction

	function automatic plan_row_t set_row(cfg_reg_t r, logic [31:0] v);
		plan_row_t p;
		p = '0;
		p.kind = ROW_CFG;
		p.rsel = r;
		p.val = v;
		return p;
	endfunction

	function automatic plan_row_t word_row(cmd_t c, logic [9:0] h);
		plan_row_t p;
		p = '0;
		p.kind = ROW_WORD;
		p.cmd = c;
		p.hall = h;
		return p;
	endfunction

	function automatic plan_row_t fixed_row(cmd_t c, logic [9:0] h, logic [4:0] pins, bit en,
			bit ext, bit busy, logic [15:0] p_pos);
		plan_row_t p;
		p = word_row(c, h);
		p.typed = 1'b1;
		p.want = '{pins, en, ext, busy, p_pos};
		return p;
	endfunction

	function automatic logic [31:0] pick_setting(cfg_reg_t r);
		int unsigned roll;
		roll = $urandom_range(0, 19);
		case (r)
			REG_STEPS_PER_REV:
				return roll == 0 ? 32'd0 : roll == 1 ? 32'd65535 : roll < 5 ? 32'd1 :
					roll < 8 ? 32'd200 : 32'($urandom_range(2, 12));
			REG_HALL_THRESHOLD:
				return roll < 3 ? 32'd0 : roll < 6 ? 32'd1023 : 32'($urandom_range(0, 1023));
			REG_RETRACT_STEPS:
				return 32'(int'($urandom_range(0, 12)) - 6);
			REG_WIRE_MODE:
				return 32'($urandom_range(0, 3));
			default:
				return roll == 0 ? 32'h00FF_FFFF : 32'($urandom_range(0, 4));
		endcase
	endfunction

	function automatic cmd_t pick_cmd();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return CMD_EXTEND;
		if (roll < 17)
			return CMD_RETRACT;
		if (roll < 19)
			return CMD_NONE;
		return CMD_TICK;
	endfunction

	function automatic logic [9:0] pick_hall();
		case ($urandom_range(0, 3))
			0: return 10'($urandom_range(0, 1023));
			1: return 10'($urandom_range(0, thresh));
			default: return (thresh == 10'd1023) ? 10'd1023 :
				10'($urandom_range(thresh + 1, 1023));
		endcase
	endfunction

	task automatic put_word(cmd_t c, logic [9:0] h, bit typed, res_t fixed);
		res_t pred;
		item_ch.valid <= 1'b1;
		item_ch.cmd <= c;
		item_ch.hall_sample <= h;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		pred = tick_controller(c, h);
		drive_q.push_back(typed ? fixed : pred);
		if (burst_left == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = $urandom_range(1, 40);
		end else begin
			burst_left--;
		end
	endtask

	// hold the sender until every expected word is back
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(cfg_reg_t r, logic [31:0] val);
		logic [23:0] v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		v = val[23:0];
		case (r)
			REG_STEPS_PER_REV:  spr = v[15:0];
			REG_STEP_INTERVAL:  interval = v;
			REG_HALL_THRESHOLD: thresh = v[9:0];
			REG_RETRACT_STEPS:  ret_cnt = v[15:0];
			REG_WIRE_MODE:      wmode = wire_mode_t'(v[1:0]);
			REG_ENABLE_SETTLE:  settle_en = v;
			REG_STEP_SETTLE:    settle_step = v;
			REG_DISABLE_SETTLE: settle_dis = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic long_retract(logic [31:0] count);
		drain();
		apb_write(REG_RETRACT_STEPS, count);
		put_word(CMD_RETRACT, pick_hall(), 1'b0, '0);
		while (phase != PH_IDLE)
			put_word(CMD_TICK, pick_hall(), 1'b0, '0);
	endtask

	task automatic report_bad(string what, res_t want, res_t got);
		bad_words++;
		if (bad_words <= 10)
			$display({"tb_top: word %0d %s: want pins=%0d en=%0d ext=%0d busy=%0d pos=%0d",
				" / got pins=%0d en=%0d ext=%0d busy=%0d pos=%0d"},
				words_seen, what, want.phase_pins, want.enable, want.extended,
				want.busy_res, want.position,
				got.phase_pins, got.enable, got.extended, got.busy_res, got.position);
	endtask

	// result side: check each word, stall on a rotating pattern
	initial begin
		res_t got, want;
		logic [15:0] pat;
		int unsigned span;
		res_ch.ready <= 1'b0;
		pat = 16'hFFFF;
		span = 0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got.phase_pins = res_ch.phase_pins;
				got.enable     = res_ch.enable;
				got.extended   = res_ch.extended;
				got.busy_res   = res_ch.busy_res;
				got.position   = res_ch.position;
				if (drive_q.size() == 0) begin
					report_bad("with none expected", '0, got);
				end else begin
					want = drive_q.pop_front();
					if (got !== want)
						report_bad("mismatch", want, got);
				end
				words_seen++;
			end
			if (span == 0) begin
				span = 64;
				pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
			end
			span--;
			res_ch.ready <= pat[0];
			pat = {pat[0], pat[15:1]};
		end
	end

	initial begin
		#100ms;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		int pause_at;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.cmd <= CMD_TICK;
		item_ch.hall_sample <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;

		plan = {
			// out of reset: idle, retracted, coils off
			fixed_row(CMD_TICK,    10'd0,    5'd0, 0, 0, 0, 16'd0),
			fixed_row(CMD_NONE,    10'd1023, 5'd0, 0, 0, 0, 16'd0),
			// extend raises enable and starts the long settle
			fixed_row(CMD_EXTEND,  10'd1023, 5'd0, 1, 0, 1, 16'd0),
			// commands while busy are dropped
			fixed_row(CMD_EXTEND,  10'd0,    5'd0, 1, 0, 1, 16'd0),
			fixed_row(CMD_RETRACT, 10'd0,    5'd0, 1, 0, 1, 16'd0),
			// shorten waits mid-settle, first step is immediate
			set_row(REG_ENABLE_SETTLE, 32'd0),
			set_row(REG_STEP_INTERVAL, 32'd0),
			set_row(REG_STEP_SETTLE, 32'd0),
			set_row(REG_DISABLE_SETTLE, 32'd0),
			word_row(CMD_TICK, 10'd1023),
			word_row(CMD_TICK, 10'd1023),
			word_row(CMD_TICK, 10'd1023),
			word_row(CMD_TICK, 10'd600),
			word_row(CMD_TICK, 10'd513),
			// sample exactly at threshold ends the extend
			word_row(CMD_TICK, 10'd512),
			word_row(CMD_EXTEND, 10'd0),
			// retract with zero count: disable wait only
			set_row(REG_WIRE_MODE, WIRE_FOUR),
			set_row(REG_RETRACT_STEPS, 32'd0),
			word_row(CMD_RETRACT, 10'd1023),
			word_row(CMD_TICK, 10'd0),
			word_row(CMD_TICK, 10'd0),
			// retract while retracted, backward from above the revolution
			set_row(REG_WIRE_MODE, WIRE_FIVE),
			set_row(REG_STEPS_PER_REV, 32'd5),
			set_row(REG_RETRACT_STEPS, 32'hFFFF_FFFD),
			word_row(CMD_RETRACT, 10'd0),
			word_row(CMD_TICK, 10'd341),
			word_row(CMD_TICK, 10'd682),
			word_row(CMD_TICK, 10'd1),
			word_row(CMD_TICK, 10'd1022),
			// unused wire mode holds coils; forward wrap at one step per revolution
			set_row(REG_WIRE_MODE, WIRE_HOLD),
			set_row(REG_STEPS_PER_REV, 32'd1),
			set_row(REG_RETRACT_STEPS, 32'd2),
			word_row(CMD_RETRACT, 10'd5),
			word_row(CMD_TICK, 10'd0),
			word_row(CMD_TICK, 10'd0),
			word_row(CMD_TICK, 10'd0),
			// zero steps per revolution pins the position
			set_row(REG_STEPS_PER_REV, 32'd0),
			set_row(REG_RETRACT_STEPS, 32'd1),
			word_row(CMD_RETRACT, 10'd7),
			word_row(CMD_TICK, 10'd0),
			word_row(CMD_TICK, 10'd0)
		};

		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain();
				apb_write(plan[i].rsel, plan[i].val);
			end else begin
				put_word(plan[i].cmd, plan[i].hall, plan[i].typed, plan[i].want);
			end
		end

		// retracts across the wrap point of a maximal revolution, one step per tick
		drain();
		apb_write(REG_STEPS_PER_REV, 32'd65535);
		apb_write(REG_STEP_INTERVAL, 32'd0);
		apb_write(REG_WIRE_MODE, WIRE_FIVE);
		apb_write(REG_HALL_THRESHOLD, 32'd1023);
		apb_write(REG_ENABLE_SETTLE, 32'd0);
		apb_write(REG_STEP_SETTLE, 32'd0);
		apb_write(REG_DISABLE_SETTLE, 32'd0);
		long_retract(32'hFFFF_FFD8);
		long_retract(32'd40);

		for (int p = 0; p < 11; p++) begin
			drain();
			for (int r = 0; r < 8; r++)
				apb_write(cfg_reg_t'(r), pick_setting(cfg_reg_t'(r)));
			pause_at = $urandom_range(0, 240);
			for (int k = 0; k < 48; k++) begin
				if (k == pause_at)
					drain();
				put_word(pick_cmd(), pick_hall(), 1'b0, '0);
			end
		end

		drain();
		repeat (8)
			@(posedge clk);
		if (bad_words == 0 && drive_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
